>>> sv/tlrs_pkg.sv
// Package for the two-level request stack: sequencer states, field widths,
// command and level codes, register map. No dependencies.
`default_nettype none

package tlrs_pkg;

    // Fixed field widths of the request and result channels
    localparam int unsigned KIND_W     = 1;
    localparam int unsigned HANDLE_W   = 16;
    localparam int unsigned PRI_W      = 4;
    localparam int unsigned COUNT_W    = 4;

    // Configuration port
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    // Register index (word address paddr[2])
    localparam logic REG_URGENT_PRIORITY = 1'b0;

    // Reset value of the urgent priority register
    localparam logic [PRI_W-1:0] URGENT_PRI_RESET = 4'd5;

    // Request kinds
    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_REMOVE  = 1'b1;

    // Levels
    localparam logic LVL_NORMAL = 1'b0;
    localparam logic LVL_URGENT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_SCAN,
        ST_CMP,
        ST_SHIFT,
        ST_MOVE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/tlrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the entry store of the request stack. No dependencies.
`default_nettype none

module tlrs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/two_level_request_stack.sv
// Two-level request stack: top level with sequencer, fill counters and
// configuration port. Depends on tlrs_pkg and tlrs_ram.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries enqueue or remove
//   requests; result channel (o_out_valid / i_out_stall) returns one result
//   per request: success, level used and both fill counts after the request.
//   One request is worked on at a time; o_in_stall is high while the
//   sequencer is busy. The result sits in an output register, so a new
//   request is taken while an earlier result still waits for the receiver.
//   Steps from accept to result valid:
//     enqueue: write at the tail of the chosen level, then hand over.
//     remove:  read and compare each entry of the normal level, then of
//              the urgent level; when found, shift every following entry
//              down one slot, then hand over; all through the single read
//              port of the entry RAM.
//   The next request is taken in the cycle after the result moves to the
//   output register.
//   If the receiver stalls, the finished request waits in the sequencer
//   until the output register is free; o_in_stall stays high meanwhile.
//   Reset empties both levels and sets urgent_priority to 5; the entry RAM
//   is not cleared (only entries below a fill count are ever read).
//   The user writes urgent_priority over the APB port only while the block is idle; it is not enforced.
`default_nettype none

module two_level_request_stack #(
    parameter int unsigned LEVEL_DEPTH = 8,
    parameter int unsigned HANDLE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tlrs_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [tlrs_pkg::HANDLE_W-1:0]    i_handle,
    input  wire logic [tlrs_pkg::PRI_W-1:0]       i_priority_req,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_success,
    output logic                                  o_level_used,
    output logic      [tlrs_pkg::COUNT_W-1:0]     o_normal_count,
    output logic      [tlrs_pkg::COUNT_W-1:0]     o_urgent_count,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tlrs_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [tlrs_pkg::PDATA_W-1:0]     pwdata,
    output logic      [tlrs_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int unsigned IW       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int unsigned CW       = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned RAM_AW   = IW + 1;
    localparam int unsigned RAM_D    = 2 * (1 << IW);
    localparam logic [CW-1:0] DEPTH_C = CW'(LEVEL_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Sequencer and control state
    tlrs_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_fill [2];
    logic [CW-1:0]    n_fill [2];
    logic             r_lvl, n_lvl;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_ok, n_ok;
    logic             r_res_lvl, n_res_lvl;
    logic [HANDLE_BITS-1:0] r_h, n_h;
    logic [tlrs_pkg::PRI_W-1:0] r_urgent_priority;

    // Output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_ok, n_out_ok;
    logic                         r_out_lvl, n_out_lvl;
    logic [tlrs_pkg::COUNT_W-1:0] r_out_ncnt, n_out_ncnt;
    logic [tlrs_pkg::COUNT_W-1:0] r_out_ucnt, n_out_ucnt;

    // RAM port
    logic                   w_we;
    logic [RAM_AW-1:0]      w_waddr;
    logic [HANDLE_BITS-1:0] w_wdata;
    logic [RAM_AW-1:0]      w_raddr;
    logic [HANDLE_BITS-1:0] w_rdata;

    // Shared conditions
    logic [CW-1:0]   w_fill_cur;
    logic [CW-1:0]   w_idx_nxt;
    logic            w_in_acc;
    logic            w_scan_end;
    logic            w_match;
    logic            w_more;
    logic            w_room;
    logic            w_out_free;
    logic            w_cfg_wr;
    logic [31:0]     w_h_ext;
    logic [31:0]     w_ncnt_ext;
    logic [31:0]     w_ucnt_ext;

    assign w_fill_cur = r_fill[r_lvl];
    assign w_idx_nxt  = r_idx + ONE_C;
    assign w_in_acc   = i_in_valid && (r_state == tlrs_pkg::ST_IDLE);
    assign w_scan_end = (r_idx >= w_fill_cur);
    assign w_match    = (w_rdata == r_h);
    assign w_more     = (w_idx_nxt < w_fill_cur);
    assign w_room     = (w_fill_cur < DEPTH_C);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_h_ext    = 32'(i_handle);
    assign w_ncnt_ext = 32'(r_fill[0]);
    assign w_ucnt_ext = 32'(r_fill[1]);

    // Entry store: level in the top address bit, slot below
    tlrs_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (RAM_D)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlrs_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_kind == tlrs_pkg::KIND_ENQUEUE) ? tlrs_pkg::ST_ENQ
                                                                  : tlrs_pkg::ST_SCAN;
                end
            end
            tlrs_pkg::ST_ENQ: begin
                n_state = tlrs_pkg::ST_FINISH;
            end
            tlrs_pkg::ST_SCAN: begin
                if (!w_scan_end) begin
                    n_state = tlrs_pkg::ST_CMP;
                end else if (r_lvl == tlrs_pkg::LVL_URGENT) begin
                    n_state = tlrs_pkg::ST_FINISH;
                end
            end
            tlrs_pkg::ST_CMP: begin
                n_state = w_match ? tlrs_pkg::ST_SHIFT : tlrs_pkg::ST_SCAN;
            end
            tlrs_pkg::ST_SHIFT: begin
                n_state = w_more ? tlrs_pkg::ST_MOVE : tlrs_pkg::ST_FINISH;
            end
            tlrs_pkg::ST_MOVE: begin
                n_state = tlrs_pkg::ST_SHIFT;
            end
            tlrs_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = tlrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and next register values
    always_comb begin
        n_fill      = r_fill;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_res_lvl   = r_res_lvl;
        n_h         = r_h;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_ok    = r_out_ok;
        n_out_lvl   = r_out_lvl;
        n_out_ncnt  = r_out_ncnt;
        n_out_ucnt  = r_out_ucnt;
        w_we        = 1'b0;
        w_waddr     = {r_lvl, r_idx[IW-1:0]};
        w_wdata     = w_rdata;
        w_raddr     = {r_lvl, r_idx[IW-1:0]};

        case (r_state)
            // take the request, pick the level for an enqueue
            tlrs_pkg::ST_IDLE: begin
                n_h       = w_h_ext[HANDLE_BITS-1:0];
                n_idx     = '0;
                n_ok      = 1'b0;
                n_res_lvl = tlrs_pkg::LVL_NORMAL;
                if (i_kind == tlrs_pkg::KIND_ENQUEUE) begin
                    n_lvl = (i_priority_req == r_urgent_priority) ? tlrs_pkg::LVL_URGENT
                                                                   : tlrs_pkg::LVL_NORMAL;
                end else begin
                    n_lvl = tlrs_pkg::LVL_NORMAL;
                end
            end
            // append at the tail, or refuse when full
            tlrs_pkg::ST_ENQ: begin
                n_res_lvl = r_lvl;
                if (w_room) begin
                    w_we         = 1'b1;
                    w_waddr      = {r_lvl, w_fill_cur[IW-1:0]};
                    w_wdata      = r_h;
                    n_fill[r_lvl] = w_fill_cur + ONE_C;
                    n_ok         = 1'b1;
                end
            end
            // read the current entry, or when the level is exhausted move on to urgent, or give up
            tlrs_pkg::ST_SCAN: begin
                if (w_scan_end && (r_lvl == tlrs_pkg::LVL_NORMAL)) begin
                    n_lvl = tlrs_pkg::LVL_URGENT;
                    n_idx = '0;
                end
            end
            // compare the entry read in the previous cycle
            tlrs_pkg::ST_CMP: begin
                if (!w_match) begin
                    n_idx = w_idx_nxt;
                end
            end
            // fetch the following entry, or close the gap
            tlrs_pkg::ST_SHIFT: begin
                w_raddr = {r_lvl, w_idx_nxt[IW-1:0]};
                if (!w_more) begin
                    n_fill[r_lvl] = w_fill_cur - ONE_C;
                    n_ok          = 1'b1;
                    n_res_lvl     = r_lvl;
                end
            end
            // move it one slot down
            tlrs_pkg::ST_MOVE: begin
                w_we    = 1'b1;
                w_waddr = {r_lvl, r_idx[IW-1:0]};
                w_wdata = w_rdata;
                n_idx   = w_idx_nxt;
            end
            // hand over to the output register
            tlrs_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_lvl   = r_res_lvl;
                    n_out_ncnt  = w_ncnt_ext[tlrs_pkg::COUNT_W-1:0];
                    n_out_ucnt  = w_ucnt_ext[tlrs_pkg::COUNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration write decode
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == tlrs_pkg::REG_URGENT_PRIORITY);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= tlrs_pkg::ST_IDLE;
            r_fill[0]         <= '0;
            r_fill[1]         <= '0;
            r_out_valid       <= 1'b0;
            r_urgent_priority <= tlrs_pkg::URGENT_PRI_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_urgent_priority <= pwdata[tlrs_pkg::PRI_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_ok       <= n_ok;
        r_res_lvl  <= n_res_lvl;
        r_h        <= n_h;
        r_out_ok   <= n_out_ok;
        r_out_lvl  <= n_out_lvl;
        r_out_ncnt <= n_out_ncnt;
        r_out_ucnt <= n_out_ucnt;
    end

    // Ports
    assign o_in_stall     = (r_state != tlrs_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_success      = r_out_ok;
    assign o_level_used   = r_out_lvl;
    assign o_normal_count = r_out_ncnt;
    assign o_urgent_count = r_out_ucnt;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == tlrs_pkg::REG_URGENT_PRIORITY)
                            ? 32'(r_urgent_priority) : '0;

endmodule

`default_nettype wire
